// ===== hdl/iaisu_pkg.sv =====
// ----------------------------------------------------------------------------
// iaisu_pkg
// Types and constants shared by the indexed array insert/search unit.
// ----------------------------------------------------------------------------
package iaisu_pkg;

  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned DefaultWidth = 32;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SHIFT,
    S_WRITE,
    S_SEARCH,
    S_DONE
  } state_e;

  typedef struct packed {
    req_e               req_type;
    logic [7:0]         index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic       status;
    logic       found;
    logic [8:0] position;
    logic [8:0] used_length;
  } out_t;

endpackage

// ===== hdl/iaisu_mem.sv =====
// ----------------------------------------------------------------------------
// iaisu_mem
// Element store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module iaisu_mem #(
  parameter int unsigned DEPTH = iaisu_pkg::DefaultDepth,
  parameter int unsigned WIDTH = iaisu_pkg::DefaultWidth,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/iaisu_ctrl.sv =====
// ----------------------------------------------------------------------------
// iaisu_ctrl
// Request sequencer: zero-fill, tail shift, binary search and the used length.
// ----------------------------------------------------------------------------
module iaisu_ctrl #(
  parameter int unsigned DEPTH = iaisu_pkg::DefaultDepth,
  parameter int unsigned WIDTH = iaisu_pkg::DefaultWidth,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  iaisu_pkg::in_t   in_data_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output iaisu_pkg::out_t  res_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [WIDTH-1:0] mem_wdata_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  logic [WIDTH-1:0] mem_rdata_i
);

  localparam int unsigned CMPW = (CW > 9) ? CW : 9;

  iaisu_pkg::state_e state_q, state_d;
  logic [CW-1:0]     used_q, used_d;
  logic [AW-1:0]     at_q, at_d;
  logic [AW-1:0]     k_q, k_d;
  logic [WIDTH-1:0]  key_q, key_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hi_q, hi_d;
  logic [CW-1:0]     mid_q, mid_d;
  logic [CW-1:0]     newlen_q, newlen_d;
  iaisu_pkg::out_t   res_q, res_d;

  logic [CMPW-1:0]   at_w;
  logic [CMPW-1:0]   used_w;
  logic [WIDTH-1:0]  word_w;
  logic              is_set;
  logic              key_lt;
  logic [CW-1:0]     lo_n;
  logic [CW-1:0]     hi_n;
  logic [CW-1:0]     mid_n;

  assign at_w   = CMPW'(in_data_i.index);
  assign used_w = CMPW'(used_q);
  assign word_w = WIDTH'(in_data_i.value);
  assign is_set = (in_data_i.req_type == iaisu_pkg::REQ_SET) || (at_w >= used_w);

  // next search bounds from the compare of the word just read
  assign key_lt = $signed(key_q) < $signed(mem_rdata_i);
  assign lo_n   = key_lt ? lo_q : mid_q + CW'(1);
  assign hi_n   = key_lt ? mid_q : hi_q;
  assign mid_n  = lo_n + ((hi_n - lo_n) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iaisu_pkg::S_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q     <= at_d;
    k_q      <= k_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    newlen_q <= newlen_d;
    res_q    <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    at_d        = at_q;
    k_d         = k_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    newlen_d    = newlen_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = at_q;
    mem_wdata_o = key_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(mid_q);

    unique case (state_q)
      iaisu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d.status      = 1'b0;
          res_d.found       = 1'b0;
          res_d.position    = '0;
          res_d.used_length = 9'(used_q);
          at_d              = AW'(at_w);
          key_d             = word_w;
          k_d               = AW'(used_q);
          unique case (in_data_i.req_type)
            iaisu_pkg::REQ_SET, iaisu_pkg::REQ_INSERT: begin
              if (is_set) begin
                if (at_w >= CMPW'(DEPTH)) begin
                  res_d.status = 1'b1;
                  state_d      = iaisu_pkg::S_DONE;
                end else begin
                  if (used_w <= at_w) begin
                    newlen_d = CW'(at_w + CMPW'(1));
                  end else begin
                    newlen_d = used_q;
                  end
                  state_d = (used_w < at_w) ? iaisu_pkg::S_FILL : iaisu_pkg::S_WRITE;
                end
              end else if (used_w >= CMPW'(DEPTH)) begin
                res_d.status = 1'b1;
                state_d      = iaisu_pkg::S_DONE;
              end else begin
                // read the last used word, the first to move up
                newlen_d    = used_q + CW'(1);
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(used_q - CW'(1));
                state_d     = iaisu_pkg::S_SHIFT;
              end
            end
            iaisu_pkg::REQ_SEARCH: begin
              if (used_q == '0) begin
                state_d = iaisu_pkg::S_DONE;
              end else begin
                lo_d        = '0;
                hi_d        = used_q;
                mid_d       = used_q >> 1;
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(used_q >> 1);
                state_d     = iaisu_pkg::S_SEARCH;
              end
            end
            iaisu_pkg::REQ_CLEAR: begin
              used_d            = '0;
              res_d.used_length = '0;
              state_d           = iaisu_pkg::S_DONE;
            end
            default: begin
              state_d = iaisu_pkg::S_DONE;
            end
          endcase
        end
      end

      iaisu_pkg::S_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = '0;
        k_d         = k_q + AW'(1);
        if (k_q + AW'(1) == at_q) begin
          state_d = iaisu_pkg::S_WRITE;
        end
      end

      iaisu_pkg::S_SHIFT: begin
        // word read last cycle lands one place up; fetch the next one down
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = mem_rdata_i;
        if (k_q - AW'(1) == at_q) begin
          state_d = iaisu_pkg::S_WRITE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q - AW'(2);
          k_d         = k_q - AW'(1);
        end
      end

      iaisu_pkg::S_WRITE: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = at_q;
        mem_wdata_o       = key_q;
        used_d            = newlen_q;
        res_d.used_length = 9'(newlen_q);
        state_d           = iaisu_pkg::S_DONE;
      end

      iaisu_pkg::S_SEARCH: begin
        if (mem_rdata_i == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = 9'(mid_q);
          state_d        = iaisu_pkg::S_DONE;
        end else if (lo_n < hi_n) begin
          lo_d        = lo_n;
          hi_d        = hi_n;
          mid_d       = mid_n;
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(mid_n);
        end else begin
          res_d.position = 9'(lo_n);
          state_d        = iaisu_pkg::S_DONE;
        end
      end

      iaisu_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = iaisu_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = iaisu_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== hdl/indexed_array_insert_search_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_array_insert_search_unit
// Word array with set, insert, binary search and clear over a used length.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i   (iaisu_pkg::in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (iaisu_pkg::out_t)
//
// one transaction at a time; clear, rejects and search on an empty store need no
// element memory access, a set zero-fills each gap entry before its write, an insert
// moves each word of the tail up one place before its write, a search probes at
// most clog2(DEPTH)+1 words; all go through the one write and one read memory port
// the result sits in an output register, so the next transaction is taken
// while the previous result waits; a full output register holds the sequencer
// reset clears the used length, the state and the output valid; stored words are kept until overwritten
module indexed_array_insert_search_unit #(
  parameter int unsigned DEPTH = iaisu_pkg::DefaultDepth,
  parameter int unsigned WIDTH = iaisu_pkg::DefaultWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  iaisu_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output iaisu_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             res_valid;
  logic             res_take;
  iaisu_pkg::out_t  res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WIDTH-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [WIDTH-1:0] mem_rdata;

  logic             out_valid_q, out_valid_d;
  iaisu_pkg::out_t  out_data_q, out_data_d;

  iaisu_ctrl #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  iaisu_mem #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output slot is free when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the indexed array insert/search unit against a behavioral mirror of
// its word store and used length: directed corner cases, sorted lists built by
// insertion and then searched, a completely full store, and random mixed
// requests, with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned Depth = iaisu_pkg::DefaultDepth;
  // upper bound on the run; past it the testbench stops and reports errors
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettleCycles = 300;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  iaisu_pkg::in_t  in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  iaisu_pkg::out_t out_data_o;

  logic signed [31:0] mirror_words [Depth];
  int unsigned        mirror_len = 0;
  iaisu_pkg::out_t    pending_results [$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  bit                 quiet = 1'b0;

  always #5 clk_i = ~clk_i;

  indexed_array_insert_search_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // binary search over the used part; stops at the first equal midpoint
  function automatic void locate_key(input logic signed [31:0] key, output bit hit,
                                     output int unsigned pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = mirror_len;
    hit = 1'b0;
    pos = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (mirror_words[mid] == key) begin
        hit = 1'b1;
        pos = mid;
        return;
      end
      if (key < mirror_words[mid]) hi = mid;
      else lo = mid + 1;
    end
    pos = lo;
  endfunction

  function automatic logic write_word(input int unsigned at, input logic signed [31:0] val);
    if (at >= Depth) return 1'b1;
    if (mirror_len <= at) begin
      for (int unsigned k = mirror_len; k < at; k++) mirror_words[k] = '0;
      mirror_len = at + 1;
    end
    mirror_words[at] = val;
    return 1'b0;
  endfunction

  function automatic iaisu_pkg::out_t apply_request(input iaisu_pkg::in_t req);
    iaisu_pkg::out_t res;
    bit              hit;
    int unsigned     pos;
    int unsigned     at;
    res = '0;
    at = 32'(req.index);
    case (req.req_type)
      iaisu_pkg::REQ_SET: begin
        res.status = write_word(at, req.value);
      end
      iaisu_pkg::REQ_INSERT: begin
        if (at >= mirror_len) begin
          res.status = write_word(at, req.value);
        end else if (mirror_len >= Depth) begin
          res.status = 1'b1;
        end else begin
          for (int unsigned k = mirror_len; k > at; k--) mirror_words[k] = mirror_words[k - 1];
          mirror_words[at] = req.value;
          mirror_len++;
        end
      end
      iaisu_pkg::REQ_SEARCH: begin
        locate_key(req.value, hit, pos);
        res.found = hit;
        res.position = 9'(pos);
      end
      iaisu_pkg::REQ_CLEAR: begin
        mirror_len = 0;
      end
    endcase
    res.used_length = 9'(mirror_len);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    iaisu_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 9'(want.status), 9'(out_data_o.status));
        check_field("found", 9'(want.found), 9'(out_data_o.found));
        check_field("position", want.position, out_data_o.position);
        check_field("used_length", want.used_length, out_data_o.used_length);
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_request(input iaisu_pkg::req_e kind, input logic [7:0] at,
                              input logic signed [31:0] val);
    iaisu_pkg::in_t req;
    int unsigned    gap;
    req.req_type = kind;
    req.index = at;
    req.value = val;
    if (!quiet && $urandom_range(99) < 12) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_request(req));
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] random_key(input bit narrow);
    logic signed [31:0] key;
    if (narrow) begin
      key = $urandom_range(16);
      key = key - 8;
    end else begin
      key = $urandom;
    end
    return key;
  endfunction

  task automatic test_directed();
    send_request(iaisu_pkg::REQ_CLEAR, 8'd0, 32'sd0);
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sd5);            // empty store
    send_request(iaisu_pkg::REQ_SET, 8'd0, 32'sh7fffffff);
    send_request(iaisu_pkg::REQ_SET, 8'd5, 32'sh80000000);        // zero-fills the gap
    send_request(iaisu_pkg::REQ_INSERT, 8'd2, -32'sd1);
    send_request(iaisu_pkg::REQ_INSERT, 8'd7, 32'sd100);          // at the end: acts as set
    send_request(iaisu_pkg::REQ_INSERT, 8'd20, 32'sd42);          // past the end with a gap
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sh80000000);
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sd0);
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sh7fffffff);
    send_request(iaisu_pkg::REQ_SET, 8'd3, 32'sd0);
    send_request(iaisu_pkg::REQ_SET, 8'd255, 32'sh55555555);      // store now full
    send_request(iaisu_pkg::REQ_INSERT, 8'd0, 32'shaaaaaaaa);     // full: rejected
    send_request(iaisu_pkg::REQ_INSERT, 8'd255, -32'sd1);         // full: rejected
    send_request(iaisu_pkg::REQ_SET, 8'd255, -32'sd2);
    send_request(iaisu_pkg::REQ_SET, 8'd0, 32'sd1);
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sd42);
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sh40000000);
    send_request(iaisu_pkg::REQ_CLEAR, 8'd255, 32'shffffffff);    // old words stay behind
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sd1);
    send_request(iaisu_pkg::REQ_INSERT, 8'd0, 32'sd9);
    send_request(iaisu_pkg::REQ_INSERT, 8'd0, 32'sd9);
    send_request(iaisu_pkg::REQ_INSERT, 8'd0, 32'sd9);
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sd9);            // equal keys
    send_request(iaisu_pkg::REQ_SEARCH, 8'd0, 32'sd10);
    drain_results();
  endtask

  // lists kept in order by inserting at the insertion point, then searched
  task automatic test_sorted_lists(input int unsigned rounds);
    int unsigned        size;
    bit                 narrow;
    bit                 hit;
    int unsigned        pos;
    logic signed [31:0] key;
    for (int unsigned r = 0; r < rounds; r++) begin
      send_request(iaisu_pkg::REQ_CLEAR, 8'($urandom), $urandom);
      size = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      narrow = 1'($urandom_range(1));
      for (int unsigned i = 0; i < size; i++) begin
        key = random_key(narrow);
        locate_key(key, hit, pos);
        send_request(iaisu_pkg::REQ_INSERT, 8'(pos), key);
        if ($urandom_range(4) == 0) begin
          send_request(iaisu_pkg::REQ_SEARCH, 8'($urandom), random_key(narrow));
        end
      end
      for (int unsigned i = 0; i < size / 2 + 2; i++) begin
        if ($urandom_range(1)) key = mirror_words[$urandom_range(mirror_len - 1)];
        else key = random_key(narrow);
        send_request(iaisu_pkg::REQ_SEARCH, 8'($urandom), key);
      end
    end
    drain_results();
  endtask

  task automatic test_full_store();
    bit                 hit;
    int unsigned        pos;
    logic signed [31:0] key;
    quiet = 1'b1;
    send_request(iaisu_pkg::REQ_CLEAR, 8'd0, 32'sd0);
    for (int unsigned i = 0; i < Depth; i++) begin
      if (mirror_len != 0 && $urandom_range(7) == 0) begin
        key = mirror_words[$urandom_range(mirror_len - 1)];
      end else begin
        key = random_key(1'b0);
      end
      locate_key(key, hit, pos);
      send_request(iaisu_pkg::REQ_INSERT, 8'(pos), key);
    end
    quiet = 1'b0;
    for (int unsigned i = 0; i < 40; i++) begin
      if ($urandom_range(1)) key = mirror_words[$urandom_range(Depth - 1)];
      else key = random_key(1'b0);
      send_request(iaisu_pkg::REQ_SEARCH, 8'($urandom), key);
    end
    for (int unsigned i = 0; i < 10; i++) begin
      send_request(iaisu_pkg::REQ_INSERT, 8'($urandom), $urandom);
    end
    for (int unsigned i = 0; i < 10; i++) begin
      send_request(iaisu_pkg::REQ_SET, 8'($urandom), $urandom);
    end
    for (int unsigned i = 0; i < 10; i++) begin
      send_request(iaisu_pkg::REQ_SEARCH, 8'($urandom), $urandom);
    end
    drain_results();
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned        pick;
    int unsigned        top;
    iaisu_pkg::req_e    kind;
    logic [7:0]         at;
    logic signed [31:0] val;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 32) kind = iaisu_pkg::REQ_SET;
      else if (pick < 64) kind = iaisu_pkg::REQ_INSERT;
      else if (pick < 95) kind = iaisu_pkg::REQ_SEARCH;
      else kind = iaisu_pkg::REQ_CLEAR;
      // mostly near the used length so long zero-fills stay rare
      top = (mirror_len + 2 > 255) ? 255 : mirror_len + 2;
      pick = $urandom_range(99);
      if (pick < 80) at = 8'($urandom_range(top));
      else if (pick < 97) at = 8'($urandom_range(255));
      else at = 8'd255;
      val = random_key(1'($urandom_range(1)));
      send_request(kind, at, val);
      if (i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_sorted_lists(22);
    test_full_store();
    test_random_mix(580);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/iaisu_pkg.sv
hdl/iaisu_mem.sv
hdl/iaisu_ctrl.sv
hdl/indexed_array_insert_search_unit.sv
test/testbench.sv
